// ===== hw/rtl/page_bitmap_allocator_unit_defines.svh =====
// assertion macros shared by the checker of the page bitmap allocator
// each macro expects clk and rst_n in the scope where it is used
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is low
`define PBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is low
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pba_pkg.sv =====
// shared types and constants of the page bitmap allocator
// no dependencies
`default_nettype none

package pba_pkg;

  localparam int MAX_PAGES    = 8192;
  localparam int PAGE_SHIFT   = 12;
  localparam int ADDR_W       = 32;
  localparam int WORD_W       = 32;
  localparam int BIT_W        = $clog2(WORD_W);
  localparam int BITMAP_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int ROW_W        = $clog2(BITMAP_WORDS);
  localparam int PAGE_W       = ROW_W + BIT_W;
  localparam int PCNT_W       = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [ADDR_W-1:0] RAM_BASE_RST = 32'h0010_0000;
  localparam logic [PCNT_W-1:0] PCNT_RST     = 14'd8192;

  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_QUERY   = 2'd2,
    OP_RESERVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_NO_FREE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] ram_base;
    logic [PCNT_W-1:0] live_pages;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic              in_use;
    status_t           status;
    logic              unaligned;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pba_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pba_bitscan.sv =====
// lowest-free-bit finder over one bitmap word
// depends on pba_pkg
`default_nettype none

module pba_bitscan (
  input  wire logic [pba_pkg::WORD_W-1:0] word,
  input  wire logic [pba_pkg::WORD_W-1:0] mask,
  output      logic                       found,
  output      logic [pba_pkg::BIT_W-1:0]  pos
);

  logic [pba_pkg::WORD_W-1:0] free_bits;

  always_comb begin
    free_bits = ~word & mask;
    found     = |free_bits;
    pos       = '0;
    // walk down so the lowest set bit wins
    for (int i = pba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = pba_pkg::BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pba_ctrl.sv =====
// sequencer of the page bitmap allocator: shared address adder, bitmap ram, word scan
// depends on pba_pkg, pba_ram, pba_bitscan
`default_nettype none

module pba_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pba_pkg::cfg_t             cfg,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [1:0]                in_opcode,
  input  wire logic [pba_pkg::ADDR_W-1:0] in_address,
  output      logic                      res_push,
  input  wire logic                      res_ready,
  output      pba_pkg::result_t          res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAP   = 7'b0000010,
    S_READ  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_ADDR  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  localparam int HI_W = pba_pkg::ADDR_W - pba_pkg::PAGE_SHIFT;

  state_t                          state_r, state_nxt;
  pba_pkg::op_t                    op_r;
  logic [pba_pkg::ADDR_W-1:0]      addr_r;
  logic [pba_pkg::PAGE_W-1:0]      page_r;
  logic [pba_pkg::ROW_W-1:0]       scan_idx_r;
  logic [pba_pkg::ROW_W-1:0]       chk_idx_r;
  logic                            chk_vld_r;
  logic [pba_pkg::BITMAP_WORDS-1:0] row_vld_r;
  pba_pkg::result_t                res_r;

  logic [pba_pkg::ADDR_W-1:0]      add_a, add_b;
  logic                            add_cin;
  logic [pba_pkg::ADDR_W:0]        add_sum;
  logic [HI_W-1:0]                 map_hi;
  logic                            map_ok;
  logic [pba_pkg::PCNT_W-1:0]      nm1;
  logic [pba_pkg::ROW_W-1:0]       last_row;
  logic [pba_pkg::BIT_W-1:0]       last_bit;
  logic                            no_pages;

  logic                            ram_we, ram_re;
  logic [pba_pkg::ROW_W-1:0]       ram_waddr, ram_raddr, rd_row;
  logic [pba_pkg::WORD_W-1:0]      ram_wdata, ram_rdata, word_eff;
  logic [pba_pkg::WORD_W-1:0]      onehot, scan_onehot, scan_mask;
  logic                            bit_sel;
  logic                            scan_found;
  logic [pba_pkg::BIT_W-1:0]       scan_pos;

  // shared adder: address minus base while mapping, base plus page offset at the end
  always_comb begin
    if (state_r == S_ADDR) begin
      add_a   = cfg.ram_base;
      add_b   = pba_pkg::ADDR_W'({page_r, {pba_pkg::PAGE_SHIFT{1'b0}}});
      add_cin = 1'b0;
    end else begin
      add_a   = addr_r;
      add_b   = ~cfg.ram_base;
      add_cin = 1'b1;
    end
    add_sum = {1'b0, add_a} + {1'b0, add_b} + (pba_pkg::ADDR_W + 1)'(add_cin);
  end

  // carry out means address >= base
  assign map_hi = add_sum[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
  assign map_ok = add_sum[pba_pkg::ADDR_W] && (map_hi < HI_W'(cfg.live_pages));

  assign no_pages = (cfg.live_pages == '0);
  assign nm1      = cfg.live_pages - pba_pkg::PCNT_W'(1);
  assign last_row = pba_pkg::ROW_W'(nm1 >> pba_pkg::BIT_W);
  assign last_bit = nm1[pba_pkg::BIT_W-1:0];

  assign ram_re    = (state_r == S_READ) || (state_r == S_SCAN);
  assign ram_raddr = (state_r == S_SCAN) ? scan_idx_r
                                         : page_r[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
  assign rd_row    = (state_r == S_CHECK) ? page_r[pba_pkg::PAGE_W-1:pba_pkg::BIT_W]
                                          : chk_idx_r;
  // rows never written since reset read as all free
  assign word_eff  = row_vld_r[rd_row] ? ram_rdata : '0;

  assign onehot      = {{(pba_pkg::WORD_W-1){1'b0}}, 1'b1} << page_r[pba_pkg::BIT_W-1:0];
  assign scan_onehot = {{(pba_pkg::WORD_W-1){1'b0}}, 1'b1} << scan_pos;
  assign bit_sel     = word_eff[page_r[pba_pkg::BIT_W-1:0]];

  // only the last row has bits past the live page count
  always_comb begin
    for (int i = 0; i < pba_pkg::WORD_W; i++) begin
      scan_mask[i] = (chk_idx_r != last_row) || (pba_pkg::BIT_W'(i) <= last_bit);
    end
  end

  pba_bitscan u_scan (
    .word  (word_eff),
    .mask  (scan_mask),
    .found (scan_found),
    .pos   (scan_pos)
  );

  pba_ram #(
    .WIDTH (pba_pkg::WORD_W),
    .DEPTH (pba_pkg::BITMAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_row;
    ram_wdata = word_eff;
    if (state_r == S_CHECK) begin
      if (op_r == pba_pkg::OP_FREE && bit_sel) begin
        ram_we    = 1'b1;
        ram_wdata = word_eff & ~onehot;
      end else if (op_r == pba_pkg::OP_RESERVE) begin
        ram_we    = 1'b1;
        ram_wdata = word_eff | onehot;
      end
    end else if (state_r == S_SCAN && chk_vld_r && scan_found) begin
      ram_we    = 1'b1;
      ram_wdata = word_eff | scan_onehot;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (pba_pkg::op_t'(in_opcode) == pba_pkg::OP_ALLOC) begin
            state_nxt = no_pages ? S_FIN : S_SCAN;
          end else begin
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP:   state_nxt = map_ok ? S_READ : S_FIN;
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_FIN;
      S_SCAN: begin
        if (chk_vld_r) begin
          if (scan_found) begin
            state_nxt = S_ADDR;
          end else if (chk_idx_r == last_row) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_ADDR:  state_nxt = S_FIN;
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chk_vld_r <= 1'b0;
      row_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      // a read was issued this cycle, so data is there next cycle
      chk_vld_r <= (state_r == S_SCAN);
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_r       <= pba_pkg::op_t'(in_opcode);
          addr_r     <= in_address;
          scan_idx_r <= '0;
          res_r.in_use    <= 1'b0;
          res_r.unaligned <= (pba_pkg::op_t'(in_opcode) == pba_pkg::OP_FREE) &&
                             (|in_address[pba_pkg::PAGE_SHIFT-1:0]);
          if (pba_pkg::op_t'(in_opcode) == pba_pkg::OP_ALLOC && no_pages) begin
            res_r.page_address <= '1;
            res_r.status       <= pba_pkg::ST_NO_FREE;
          end else begin
            res_r.page_address <= '0;
            res_r.status       <= pba_pkg::ST_OK;
          end
        end
      end
      S_MAP: begin
        page_r <= add_sum[pba_pkg::PAGE_SHIFT +: pba_pkg::PAGE_W];
        if (!map_ok) begin
          res_r.status <= pba_pkg::ST_RANGE;
        end
      end
      S_CHECK: begin
        if (op_r == pba_pkg::OP_QUERY) begin
          res_r.in_use <= bit_sel;
        end
        if (op_r == pba_pkg::OP_FREE && !bit_sel) begin
          res_r.status <= pba_pkg::ST_NOT_ALLOC;
        end
      end
      S_SCAN: begin
        chk_idx_r <= scan_idx_r;
        if (scan_idx_r != last_row) begin
          scan_idx_r <= scan_idx_r + pba_pkg::ROW_W'(1);
        end
        if (chk_vld_r) begin
          if (scan_found) begin
            page_r <= {chk_idx_r, scan_pos};
          end else if (chk_idx_r == last_row) begin
            res_r.page_address <= '1;
            res_r.status       <= pba_pkg::ST_NO_FREE;
          end
        end
      end
      S_ADDR: begin
        res_r.page_address <= add_sum[pba_pkg::ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign res_push = (state_r == S_FIN);
  assign res      = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/page_bitmap_allocator_unit.sv =====
// Page bitmap allocator: one bit per 4 KiB page above ram_base, kept in a
// 256 x 32 bitmap ram that is read one word per cycle. The block works on one
// transaction at a time and holds in_stall high from accept until its result
// has moved into the output register. Free, query and reserve step through
// map, read, check and finish, or map and finish when the address is out of
// range. Allocate scans bitmap words through the single ram read port, one
// word per cycle behind the registered read, up to the first word holding a
// free page, then steps through address and finish. With no free page it
// scans all live words and then finishes, and with a page count of zero it
// goes straight to finish. A full, stalled output register holds the finish
// step for as long as out_stall stays high. The block goes back to idle when
// the result is loaded and then accepts the next transaction. Rows not yet
// written since reset read as free, so there is no clearing pass after reset.
// Depends on pba_pkg and pba_ctrl.
`default_nettype none

module page_bitmap_allocator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [pba_pkg::ADDR_W-1:0]     in_address,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [pba_pkg::ADDR_W-1:0]     out_page_address,
  output      logic                          out_in_use,
  output      logic [1:0]                    out_status,
  output      logic                          out_unaligned
);

  logic [pba_pkg::ADDR_W-1:0] ram_base_r;
  logic [pba_pkg::PCNT_W-1:0] page_count_r;
  pba_pkg::cfg_t              cfg;
  logic                       res_push, res_ready;
  pba_pkg::result_t           res, out_res_r;
  logic                       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r   <= pba_pkg::RAM_BASE_RST;
      page_count_r <= pba_pkg::PCNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pba_pkg::CFG_RAM_BASE:   ram_base_r   <= cfg_wdata[pba_pkg::ADDR_W-1:0];
        pba_pkg::CFG_PAGE_COUNT: page_count_r <= cfg_wdata[pba_pkg::PCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp the count to the built capacity
  always_comb begin
    cfg.ram_base = ram_base_r;
    if (32'(page_count_r) > 32'(pba_pkg::MAX_PAGES)) begin
      cfg.live_pages = pba_pkg::PCNT_W'(pba_pkg::MAX_PAGES);
    end else begin
      cfg.live_pages = page_count_r;
    end
  end

  pba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_address (in_address),
    .res_push   (res_push),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_page_address = out_res_r.page_address;
  assign out_in_use       = out_res_r.in_use;
  assign out_status       = out_res_r.status;
  assign out_unaligned    = out_res_r.unaligned;

endmodule

`default_nettype wire

// ===== hw/rtl/pba_checker.sv =====
// port-level checks of the page bitmap allocator, bound to the top level
// depends on pba_pkg and page_bitmap_allocator_unit_defines.svh
`default_nettype none

`include "page_bitmap_allocator_unit_defines.svh"

module pba_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [pba_pkg::ADDR_W-1:0] out_page_address,
  input wire logic                      out_in_use,
  input wire logic [1:0]                out_status,
  input wire logic                      out_unaligned
);

  // a transaction keeps the block busy in the following cycle
  `PBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")

  `PBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_page_address) && $stable(out_status), "stalled result changed")

  `PBA_ASSERT_NOW(a_nofree_addr, out_valid && out_status == pba_pkg::ST_NO_FREE, out_page_address == '1, "no free page without all-ones address")

  `PBA_ASSERT_NOW(a_in_use_ok, out_valid && out_in_use, out_status == pba_pkg::ST_OK, "in_use with error status")

  // only free raises unaligned, and free never returns an address
  `PBA_ASSERT_NOW(a_unaligned_free, out_valid && out_unaligned, out_page_address == '0 && !out_in_use, "unaligned on a non-free result")

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_page_address (out_page_address),
  .out_in_use       (out_in_use),
  .out_status       (out_status),
  .out_unaligned    (out_unaligned)
);

`default_nettype wire
